[rtl/dual_stack_shared_buffer_assert.svh]
// assertion macros for the dual stack shared buffer checker
// depends on nothing; the including module provides clk_i and rst_ni
`ifndef DUAL_STACK_SHARED_BUFFER_ASSERT_SVH
`define DUAL_STACK_SHARED_BUFFER_ASSERT_SVH

// concurrent assertion on a given clock, off while reset is asserted
`define DSSB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define DSSB_ASSERT(label, prop, msg) \
  `DSSB_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[rtl/dssb_pkg.sv]
// shared types and constants for the dual stack shared buffer
// depends on nothing
package dssb_pkg;

  // field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned APB_DW = 32;

  // capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  // register index of capacity in the config space
  localparam logic [CFG_AW-3:0] REG_CAPACITY = 1'b0;

  // request operation codes
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // memory command from control to storage
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

[rtl/dual_stack_shared_buffer.sv]
// top level of the dual stack shared buffer: config port, control and memory
// depends on dssb_pkg, dssb_ctrl and dssb_mem
//
// Two LIFO stacks share one buffer of MAX_DEPTH 32-bit words. The first
// stack grows up from entry 0, the second down from min(capacity, depth) - 1.
// Request channel: operation_i, stack_select_i and push_value_i are taken
// at a clock edge with start high and busy low. busy is high only in the
// access cycle of a capacity write, so otherwise a new request can be
// issued every cycle.
// Result channel: done_o is high for exactly one cycle, the cycle after the
// request, with status, peeked value, both counts and both empty flags.
// Throughput is one request per cycle while busy is low; the buffer memory
// is single-port with a registered read.
// The receiver cannot stall: each result shows for one cycle only.
// Config: capacity is written over the APB port at address 0; a write
// empties both stacks. Write it only while no result is outstanding.
// Reset clears both counts and sets capacity to 1024; buffer contents are
// unknown until written, and no clearing pass is run.
module dual_stack_shared_buffer
  import dssb_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request channel
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation_i,
  input  logic                     stack_select_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  // result channel
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic [CNT_W-1:0]         first_count_o,
  output logic [CNT_W-1:0]         second_count_o,
  output logic                     first_empty_o,
  output logic                     second_empty_o,
  // config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned AddrW = $clog2(MAX_DEPTH);

  logic              req_valid;
  logic              cap_sel;
  logic              cfg_wr;
  logic [CNT_W-1:0]  capacity;
  mem_cmd_t          mem_cmd;
  logic [AddrW-1:0]  mem_addr;
  logic [DATA_W-1:0] mem_rd_data;
  logic [DATA_W-1:0] top_value;
  status_e           status;

  // request handshake, held off while the capacity is written
  assign busy      = cfg_wr;
  assign req_valid = start && !busy;

  // config register decode
  assign cap_sel = (paddr[CFG_AW-1:2] == REG_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && pready && cap_sel;
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? {{(APB_DW-CNT_W){1'b0}}, capacity} : '0;

  dssb_ctrl #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .op_i           (op_e'(operation_i)),
    .sel_i          (stack_select_i),
    .cfg_wr_i       (cfg_wr),
    .cfg_data_i     (pwdata[CNT_W-1:0]),
    .capacity_o     (capacity),
    .mem_cmd_o      (mem_cmd),
    .mem_addr_o     (mem_addr),
    .mem_rd_data_i  (mem_rd_data),
    .done_o         (done_o),
    .status_o       (status),
    .top_value_o    (top_value),
    .first_count_o  (first_count_o),
    .second_count_o (second_count_o)
  );

  dssb_mem #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .cmd_i     (mem_cmd),
    .addr_i    (mem_addr),
    .wr_data_i (push_value_i),
    .rd_data_o (mem_rd_data)
  );

  // result fields
  assign status_o       = status;
  assign top_value_o    = top_value;
  assign first_empty_o  = (first_count_o == '0);
  assign second_empty_o = (second_count_o == '0);

endmodule

[rtl/dssb_mem.sv]
// shared stack buffer: one synchronous memory, one port, registered read
// depends on dssb_pkg
module dssb_mem
  import dssb_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 1024,
  parameter int unsigned AddrW     = $clog2(MAX_DEPTH)
) (
  input  logic              clk_i,
  input  mem_cmd_t          cmd_i,
  input  logic [AddrW-1:0]  addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [MAX_DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // write on push, read on peek, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/dssb_ctrl.sv]
// stack control: fill counters, capacity register, address and status logic
// depends on dssb_pkg; drives the dssb_mem command port
module dssb_ctrl
  import dssb_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 1024,
  parameter int unsigned AddrW     = $clog2(MAX_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  op_e               op_i,
  input  logic              sel_i,
  input  logic              cfg_wr_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  output logic [CNT_W-1:0]  capacity_o,
  output mem_cmd_t          mem_cmd_o,
  output logic [AddrW-1:0]  mem_addr_o,
  input  logic [DATA_W-1:0] mem_rd_data_i,
  output logic              done_o,
  output status_e           status_o,
  output logic [DATA_W-1:0] top_value_o,
  output logic [CNT_W-1:0]  first_count_o,
  output logic [CNT_W-1:0]  second_count_o
);

  localparam int unsigned CapLimit = (MAX_DEPTH > 2047) ? 2047 : MAX_DEPTH;

  logic [CNT_W-1:0] capacity_q;
  logic [CNT_W-1:0] first_q, first_d;
  logic [CNT_W-1:0] second_q, second_d;
  logic             done_q;
  status_e          status_q, status_d;
  logic             peek_ok_q;
  logic [CNT_W-1:0] cap_use;
  logic [CNT_W:0]   fill_sum;
  logic [CNT_W-1:0] sel_fill;
  logic [CNT_W-1:0] addr;
  mem_cmd_t         cmd;

  // capacity in use, saturated to the buffer depth
  assign cap_use  = (capacity_q > CNT_W'(CapLimit)) ? CNT_W'(CapLimit) : capacity_q;
  assign fill_sum = {1'b0, first_q} + {1'b0, second_q};
  assign sel_fill = sel_i ? second_q : first_q;

  // next fills, status and memory access for the request
  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    status_d = ST_OK;
    cmd      = '0;
    addr     = '0;
    if (cfg_wr_i) begin
      first_d  = '0;
      second_d = '0;
    end else if (req_valid_i) begin
      case (op_i)
        OP_PUSH: begin
          if (fill_sum >= {1'b0, cap_use}) begin
            status_d = ST_FULL;
          end else begin
            cmd.wr_en = 1'b1;
            if (!sel_i) begin
              addr    = first_q;
              first_d = first_q + CNT_W'(1);
            end else begin
              addr     = cap_use - CNT_W'(1) - second_q;
              second_d = second_q + CNT_W'(1);
            end
          end
        end
        OP_POP: begin
          if (sel_fill == '0) begin
            status_d = ST_EMPTY;
          end else if (!sel_i) begin
            first_d = first_q - CNT_W'(1);
          end else begin
            second_d = second_q - CNT_W'(1);
          end
        end
        OP_PEEK: begin
          if (sel_fill == '0) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.rd_en = 1'b1;
            addr      = sel_i ? (cap_use - second_q) : (first_q - CNT_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // capacity register and fill counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      first_q    <= '0;
      second_q   <= '0;
    end else begin
      if (cfg_wr_i) begin
        capacity_q <= cfg_data_i;
      end
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  // result registers, valid the cycle after the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      peek_ok_q <= 1'b0;
    end else begin
      done_q    <= req_valid_i && !cfg_wr_i;
      status_q  <= status_d;
      peek_ok_q <= cmd.rd_en;
    end
  end

  assign mem_cmd_o      = cmd;
  assign mem_addr_o     = AddrW'(addr);
  assign capacity_o     = capacity_q;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign top_value_o    = peek_ok_q ? mem_rd_data_i : '0;
  assign first_count_o  = first_q;
  assign second_count_o = second_q;

endmodule

[rtl/dssb_checker.sv]
// port-level checker for the dual stack shared buffer, bound to the top level
// depends on dual_stack_shared_buffer_assert.svh and dssb_pkg
`include "dual_stack_shared_buffer_assert.svh"

module dssb_checker
  import dssb_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic [CNT_W-1:0]        first_count_o,
  input logic [CNT_W-1:0]        second_count_o,
  input logic                    first_empty_o,
  input logic                    second_empty_o,
  input logic [APB_DW-1:0]       prdata,
  input logic [CFG_AW-1:0]       paddr
);

  // every request gets its result on the next cycle
  `DSSB_ASSERT(a_req_done, (start && !busy) |=> done_o, "request without result")

  // no result without a request in the cycle before
  `DSSB_ASSERT(a_done_req, done_o |-> $past(start && !busy), "result without request")

  // both stacks together never hold more than the capacity
  `DSSB_ASSERT(a_fill_cap, (done_o && paddr[CFG_AW-1:2] == REG_CAPACITY) |-> ({1'b0, first_count_o} + {1'b0, second_count_o} <= {1'b0, prdata[CNT_W-1:0]}), "fills exceed capacity")

  // empty flags follow the counts
  `DSSB_ASSERT(a_empty_flags, done_o |-> ((first_empty_o == (first_count_o == '0)) && (second_empty_o == (second_count_o == '0))), "empty flag mismatch")

endmodule

bind dual_stack_shared_buffer dssb_checker u_checker (.*);

[dv/dual_stack_shared_buffer_test.sv]
// self-checking testbench for dual_stack_shared_buffer: push, pop and peek on
// two stacks that share one buffer, with capacity changes over the APB port
// depends on dssb_pkg and the dual_stack_shared_buffer rtl
module dual_stack_shared_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dssb_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned QUIET_LIMIT = 2000;

  // one request as queued for the driver
  typedef struct {
    op_e               op;
    logic              sel;
    logic [DATA_W-1:0] value;
  } stack_req_t;

  // one result as predicted for the monitor
  typedef struct {
    logic [1:0]        status;
    logic [DATA_W-1:0] top;
    logic [CNT_W-1:0]  first_cnt;
    logic [CNT_W-1:0]  second_cnt;
    logic              first_empty;
    logic              second_empty;
  } stack_result_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     start          = 1'b0;
  logic                     busy;
  logic [1:0]               operation_i    = OP_NOP;
  logic                     stack_select_i = 1'b0;
  logic signed [DATA_W-1:0] push_value_i   = '0;
  logic                     done_o;
  logic [1:0]               status_o;
  logic signed [DATA_W-1:0] top_value_o;
  logic [CNT_W-1:0]         first_count_o;
  logic [CNT_W-1:0]         second_count_o;
  logic                     first_empty_o;
  logic                     second_empty_o;
  logic                     psel           = 1'b0;
  logic                     penable        = 1'b0;
  logic                     pwrite         = 1'b0;
  logic [CFG_AW-1:0]        paddr          = '0;
  logic [APB_DW-1:0]        pwdata         = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  stack_req_t    pending_reqs[$];
  stack_result_t expected_results[$];
  stack_req_t    next_req;
  stack_result_t got_res;
  stack_result_t want_res;
  int            error_count    = 0;
  int            accepted_count = 0;
  int            quiet_cycles   = 0;

  // predictor state: buffer, fills and capacity register
  logic [DATA_W-1:0] stack_mem [DEPTH];
  int unsigned       up_fill   = 0;
  int unsigned       down_fill = 0;
  int unsigned       cap_reg   = CAP_RESET;

  dual_stack_shared_buffer #(
    .MAX_DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .top_value_o    (top_value_o),
    .first_count_o  (first_count_o),
    .second_count_o (second_count_o),
    .first_empty_o  (first_empty_o),
    .second_empty_o (second_empty_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock, 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // apply one request to the predicted stacks and return the expected result
  function automatic stack_result_t predict_stack_op(op_e op, logic sel,
                                                     logic [DATA_W-1:0] value);
    stack_result_t res;
    int unsigned   eff_cap;
    int unsigned   fill;
    eff_cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    fill    = sel ? down_fill : up_fill;
    res.status = ST_OK;
    res.top    = '0;
    case (op)
      OP_PUSH: begin
        if (up_fill + down_fill >= eff_cap) begin
          res.status = ST_FULL;
        end else if (sel) begin
          stack_mem[eff_cap - 1 - down_fill] = value;
          down_fill++;
        end else begin
          stack_mem[up_fill] = value;
          up_fill++;
        end
      end
      OP_POP: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else if (sel) begin
          down_fill--;
        end else begin
          up_fill--;
        end
      end
      OP_PEEK: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.top = sel ? stack_mem[eff_cap - down_fill] : stack_mem[up_fill - 1];
        end
      end
      default: begin
      end
    endcase
    res.first_cnt    = CNT_W'(up_fill);
    res.second_cnt   = CNT_W'(down_fill);
    res.first_empty  = (up_fill == 0);
    res.second_empty = (down_fill == 0);
    return res;
  endfunction

  // random gap in the request stream, none during the calm stretch
  function automatic bit take_gap();
    if (accepted_count >= 300 && accepted_count < 700) begin
      return 1'b0;
    end
    return $urandom_range(99) < 24;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_stack_op(op_e'(operation_i), stack_select_i,
                                                    push_value_i));
        accepted_count++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && !take_gap()) begin
          next_req = pending_reqs.pop_front();
          start          <= 1'b1;
          operation_i    <= next_req.op;
          stack_select_i <= next_req.sel;
          push_value_i   <= next_req.value;
        end else begin
          // junk on the payload while no request is offered
          start          <= 1'b0;
          operation_i    <= 2'($urandom);
          stack_select_i <= 1'($urandom);
          push_value_i   <= $urandom;
        end
      end
    end
  end

  // compare one field of a result
  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      got_res = '{status_o, top_value_o, first_count_o, second_count_o,
                  first_empty_o, second_empty_o};
      if (expected_results.size() == 0) begin
        $error("result with no request waiting: status %0d", status_o);
        error_count++;
      end else begin
        want_res = expected_results.pop_front();
        check_field("status", want_res.status, got_res.status);
        check_field("top_value", want_res.top, got_res.top);
        check_field("first_count", want_res.first_cnt, got_res.first_cnt);
        check_field("second_count", want_res.second_cnt, got_res.second_cnt);
        check_field("first_empty", want_res.first_empty, got_res.first_empty);
        check_field("second_empty", want_res.second_empty, got_res.second_empty);
      end
    end
  end

  // watchdog on cycles with no request, result or register access
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o === 1'b1 || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(input op_e op, input logic sel, input logic [DATA_W-1:0] value);
    stack_req_t r;
    r.op    = op;
    r.sel   = sel;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  // random requests, push_pct percent pushes and the rest pop, peek or no-op
  task automatic queue_random(input int count, input int push_pct);
    stack_req_t r;
    int         roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        r.op = OP_PUSH;
      end else begin
        roll = $urandom_range(99);
        r.op = (roll < 48) ? OP_POP : (roll < 93) ? OP_PEEK : OP_NOP;
      end
      r.sel = 1'($urandom);
      case ($urandom_range(7))
        0:       r.value = 32'h8000_0000;
        1:       r.value = 32'h7fff_ffff;
        2:       r.value = '0;
        3:       r.value = '1;
        default: r.value = $urandom;
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  // wait until every queued request has been taken and answered
  task automatic drain_requests();
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  // apb write of the capacity register; empties both stacks
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= APB_DW'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg   = cap;
    up_fill   = 0;
    down_fill = 0;
  endtask

  // stimulus sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty stacks, no-op, value extremes, peek and pop order
    queue_req(OP_PEEK, 1'b0, '0);
    queue_req(OP_POP,  1'b1, '0);
    queue_req(OP_NOP,  1'b0, 32'hdead_beef);
    queue_req(OP_PUSH, 1'b0, 32'h7fff_ffff);
    queue_req(OP_PUSH, 1'b0, 32'h8000_0000);
    queue_req(OP_PUSH, 1'b1, 32'hffff_ffff);
    queue_req(OP_PUSH, 1'b1, 32'h0000_0000);
    queue_req(OP_PEEK, 1'b0, '0);
    queue_req(OP_PEEK, 1'b1, '1);
    queue_req(OP_POP,  1'b0, '0);
    queue_req(OP_PEEK, 1'b0, '0);
    queue_req(OP_POP,  1'b1, '0);
    queue_req(OP_PEEK, 1'b1, '0);
    queue_req(OP_POP,  1'b0, '0);
    queue_req(OP_POP,  1'b1, '0);
    queue_req(OP_POP,  1'b0, '0);
    queue_req(OP_NOP,  1'b1, '1);
    drain_requests();

    // zero capacity refuses every push
    write_capacity(11'd0);
    queue_req(OP_PUSH, 1'b0, 32'h1234_5678);
    queue_req(OP_PUSH, 1'b1, 32'h8765_4321);
    queue_req(OP_POP,  1'b0, '0);
    queue_req(OP_PEEK, 1'b1, '0);
    drain_requests();

    // single entry shared by both stacks
    write_capacity(11'd1);
    queue_req(OP_PUSH, 1'b1, 32'h5a5a_5a5a);
    queue_req(OP_PUSH, 1'b0, 32'ha5a5_a5a5);
    queue_req(OP_PEEK, 1'b1, '0);
    queue_req(OP_POP,  1'b1, '0);
    drain_requests();

    // full capacity, mostly pushes so the buffer fills up
    write_capacity(11'd1024);
    queue_random(1250, 90);
    drain_requests();

    // capacity above the buffer depth saturates
    write_capacity(11'd2047);
    queue_random(30, 50);
    drain_requests();

    // random capacities, small ones favored so full shows up often
    repeat (10) begin
      case ($urandom_range(5))
        0:       write_capacity(CNT_W'($urandom_range(8, 1)));
        1:       write_capacity(CNT_W'($urandom_range(40, 2)));
        2:       write_capacity(11'd0);
        3:       write_capacity(11'd1024);
        4:       write_capacity(CNT_W'($urandom_range(2047, 1025)));
        default: write_capacity(CNT_W'($urandom_range(2047, 0)));
      endcase
      queue_random(30, 50);
      drain_requests();
    end

    repeat (4) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[dual_stack_shared_buffer.f]
+incdir+rtl
rtl/dssb_pkg.sv
rtl/dssb_mem.sv
rtl/dssb_ctrl.sv
rtl/dual_stack_shared_buffer.sv
rtl/dssb_checker.sv
dv/dual_stack_shared_buffer_test.sv
